// ===== src/serial_command_frame_decoder_macros.svh =====
// Assertion macros for the serial command frame decoder.
// Define NO_ASSERTIONS to compile every check away; used by the top level only.
`ifndef SERIAL_COMMAND_FRAME_DECODER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and held off during reset.
`define SCFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scfd assertion failed");
// Next-cycle implication, sampled on clk and held off during reset.
`define SCFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scfd assertion failed");
`else
`define SCFD_ASSERT_IMP(lbl, ante, cons)
`define SCFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/scfd_pkg.sv =====
// Shared types, constants and codes of the serial command frame decoder.
// No dependencies; every module imports this package.
package scfd_pkg;

	localparam int WIN_LEN = 8;
	localparam int CNT_W = 5;
	localparam int MAX_BURST_DEF = 30;
	localparam int FRAME_CHECK_AT = 8;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// Window positions that hold payload or check byte and are not compared.
	localparam logic [WIN_LEN-1:0] FREE_POS_MASK = 8'b0011_1100;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ENABLE = 3'd4;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_STOP = 3'd1,
		ACT_SEND = 3'd2,
		ACT_DUP = 3'd3,
		ACT_ACK = 3'd4
	} action_t;

	typedef logic [WIN_LEN-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic burst_last;
	} in_item_t;

	typedef struct packed {
		action_t action;
		logic [23:0] payload;
		logic cmd_parity;
	} out_item_t;

	// Flags of the byte that has just entered the window.
	typedef struct packed {
		logic valid;
		logic last;
		logic chk_en;
		logic ovl;
	} frm_s1_t;

	// Burst summary handed to the decision stage at the end of a burst.
	typedef struct packed {
		logic valid;
		logic found;
		logic [23:0] payload;
		logic parity;
	} frm_s2_t;

endpackage

// ===== src/scfd_cell.sv =====
// One byte cell of the sliding window: holds a byte, takes its neighbor's on a shift,
// and compares its byte to a reference. Depends on scfd_pkg.
module scfd_cell
	import scfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] d,
	input  logic [7:0] ref_byte,
	output logic [7:0] q,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;
	assign hit = (byte_q == ref_byte);

endmodule

// ===== src/scfd_check.sv =====
// Frame check stage: verifies the checksum of the window, keeps the first frame of a
// burst and hands a burst summary on at its last byte. Depends on scfd_pkg.
module scfd_check
	import scfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  frm_s1_t frm_s1,
	input  window_t win,
	input  logic    hdr_ok,
	output frm_s2_t frm_s2
);

	logic        found_q;
	logic [23:0] fpay_q;
	logic        fpar_q;
	logic [7:0]  psum;
	logic [15:0] psq;
	logic [5:0]  chk_calc;
	logic        hit;
	logic        found_nx;
	logic [23:0] pay_nx;
	logic        par_nx;
	frm_s2_t     s2_q;

	always_comb begin
		// Only the low six bits of the square are needed, so the sum wraps at 8 bits.
		psum = win[2] + win[3] + win[4];
		psq = psum * psum;
		chk_calc = ~psq[5:0];
		hit = frm_s1.valid && frm_s1.chk_en && !found_q && hdr_ok
			&& (win[5][5:0] == chk_calc);
		found_nx = found_q || hit;
		pay_nx = hit ? {win[2], win[3], win[4]} : fpay_q;
		par_nx = hit ? win[5][6] : fpar_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			s2_q <= '0;
		end else begin
			s2_q.valid <= frm_s1.valid && frm_s1.last;
			if (frm_s1.valid) begin
				found_q <= frm_s1.last ? 1'b0 : found_nx;
			end
			if (frm_s1.valid && frm_s1.last) begin
				s2_q.found <= found_nx && !frm_s1.ovl;
				s2_q.payload <= pay_nx;
				s2_q.parity <= par_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frm_s1.valid) begin
			fpay_q <= pay_nx;
			fpar_q <= par_nx;
		end
	end

	assign frm_s2 = s2_q;

endmodule

// ===== src/scfd_fifo.sv =====
// Small result queue between the decision stage and the output channel.
// Depends on scfd_pkg.
module scfd_fifo
	import scfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  out_item_t           wr_data,
	input  logic                rd_ready,
	output logic                rd_valid,
	output out_item_t           rd_data,
	output logic [OQ_CNT_W-1:0] count
);

	localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;

	out_item_t          mem [OQ_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic               pop;

	assign rd_valid = (count_q != '0);
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/serial_command_frame_decoder.sv =====
// Serial command frame decoder, top level. Uses scfd_pkg, scfd_cell, scfd_check, scfd_fifo.
// Throughput: one byte per cycle while input ready is high; input ready depends only on room
// in the 4-entry result queue, counting results still on their way through the check stages.
// A burst's result passes the window cells, then frame check, then decision into the queue.
// Reset (arst_n low, asynchronous): registers take their reset values, accept_enable is set,
// the burst state and previous command are cleared and the result queue is emptied.
`include "serial_command_frame_decoder_macros.svh"

module serial_command_frame_decoder
	import scfd_pkg::*;
#(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	// Configuration registers.
	logic [7:0] head_first_q;
	logic [7:0] head_second_q;
	logic [7:0] tail_first_q;
	logic [7:0] tail_second_q;
	logic       accept_en_q;

	// Burst bookkeeping for the byte being accepted.
	logic [CNT_W-1:0] cnt_q;
	logic             ovl_q;
	logic [CNT_W-1:0] cnt_nx;
	logic             ovl_nx;
	logic             accept;

	// Window cell row and its compare results.
	window_t          win;
	window_t          cell_d;
	window_t          cell_ref;
	logic [WIN_LEN-1:0] cell_hit;
	logic             hdr_ok;

	frm_s1_t frm_s1;
	frm_s2_t frm_s2;

	// Previous recorded command and the decision for the finishing burst.
	logic [23:0] last_pay_q;
	logic        last_par_q;
	out_item_t   dec;
	logic        record;

	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W:0]   oq_committed;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_first_q <= '0;
			head_second_q <= '0;
			tail_first_q <= '0;
			tail_second_q <= '0;
			accept_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HEAD_FIRST: head_first_q <= cfg_wdata;
				CFG_HEAD_SECOND: head_second_q <= cfg_wdata;
				CFG_TAIL_FIRST: tail_first_q <= cfg_wdata;
				CFG_TAIL_SECOND: tail_second_q <= cfg_wdata;
				CFG_ACCEPT_ENABLE: accept_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// The byte count saturates at the maximum burst length; one more byte marks the
	// burst as overlong, which disables frame checks and forces a result of none.
	always_comb begin
		if (cnt_q >= CNT_W'(MAX_BURST)) begin
			cnt_nx = cnt_q;
			ovl_nx = 1'b1;
		end else begin
			cnt_nx = cnt_q + 1'b1;
			ovl_nx = ovl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovl_q <= 1'b0;
			frm_s1 <= '0;
		end else begin
			frm_s1.valid <= accept;
			if (accept) begin
				cnt_q <= in_data.burst_last ? '0 : cnt_nx;
				ovl_q <= in_data.burst_last ? 1'b0 : ovl_nx;
				frm_s1.last <= in_data.burst_last;
				frm_s1.chk_en <= !ovl_nx && (cnt_nx >= CNT_W'(FRAME_CHECK_AT));
				frm_s1.ovl <= ovl_nx;
			end
		end
	end

	// The window is never cleared between bursts: a check only runs once eight bytes
	// of the current burst have arrived, by which time every cell holds one of them.
	// Cell 0 holds the oldest byte and cell WIN_LEN-1 the newest.
	always_comb begin
		cell_ref = '0;
		cell_ref[0] = head_first_q;
		cell_ref[1] = head_second_q;
		cell_ref[WIN_LEN-2] = tail_first_q;
		cell_ref[WIN_LEN-1] = tail_second_q;
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			cell_d[i] = win[i+1];
		end
		cell_d[WIN_LEN-1] = in_data.rx_byte;
	end

	for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
		scfd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept),
			.d        (cell_d[g]),
			.ref_byte (cell_ref[g]),
			.q        (win[g]),
			.hit      (cell_hit[g])
		);
	end

	// Header and trailer positions must match; payload and check positions are free.
	assign hdr_ok = &(cell_hit | FREE_POS_MASK);

	scfd_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.frm_s1 (frm_s1),
		.win    (win),
		.hdr_ok (hdr_ok),
		.frm_s2 (frm_s2)
	);

	// Decision at the end of a burst. A stop command passes regardless of the accept
	// enable; with accepting disabled any other frame reports none but still shows its
	// payload. Only send and duplicate outcomes update the previous command.
	always_comb begin
		dec.action = ACT_NONE;
		dec.payload = '0;
		dec.cmd_parity = 1'b0;
		record = 1'b0;
		if (frm_s2.found) begin
			dec.payload = frm_s2.payload;
			dec.cmd_parity = frm_s2.parity;
			if (frm_s2.payload == '1) begin
				dec.action = ACT_STOP;
			end else if (!accept_en_q) begin
				dec.action = ACT_NONE;
			end else if (frm_s2.payload == '0) begin
				dec.action = ACT_ACK;
			end else begin
				if (frm_s2.payload == last_pay_q && frm_s2.parity == last_par_q) begin
					dec.action = ACT_DUP;
				end else begin
					dec.action = ACT_SEND;
				end
				record = frm_s2.valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pay_q <= '0;
			last_par_q <= 1'b0;
		end else if (record) begin
			last_pay_q <= frm_s2.payload;
			last_par_q <= frm_s2.parity;
		end
	end

	scfd_fifo u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (frm_s2.valid),
		.wr_data  (dec),
		.rd_ready (out_ready),
		.rd_valid (out_valid),
		.rd_data  (out_data),
		.count    (oq_count)
	);

	// A byte is taken only if the queue can hold its result on top of every result
	// already queued or still on its way through the check stages.
	always_comb begin
		oq_committed = {1'b0, oq_count}
			+ (OQ_CNT_W + 1)'(frm_s1.valid && frm_s1.last)
			+ (OQ_CNT_W + 1)'(frm_s2.valid);
	end

	assign in_ready = (oq_committed < (OQ_CNT_W + 1)'(OQ_DEPTH));

	// A full result queue must hold off new transactions.
	`SCFD_ASSERT_IMP(a_full_blocks_input, oq_count == OQ_CNT_W'(OQ_DEPTH), !in_ready)
	// The overlong mark is only ever set with the count sitting at its limit.
	`SCFD_ASSERT_IMP(a_ovl_at_limit, ovl_q, cnt_q == CNT_W'(MAX_BURST))
	// The last byte of a burst restarts the count for the next burst.
	`SCFD_ASSERT_NXT(a_burst_restart, accept && in_data.burst_last, cnt_q == '0 && !ovl_q)

endmodule
